@@ sv/frs_pkg.sv @@
`timescale 1ns / 1ps

package frs_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int DEPTH    = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RUSE_W   = $clog2(MAX_ROWS + 1);
	localparam int CUSE_W   = $clog2(MAX_COLS + 1);
	localparam int GEO_W    = 11;
	localparam int CFG_W    = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic [7:0] BLANK_CELL = 8'd46;
	localparam logic [6:0] CANVAS_RESET = 7'd64;

	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_COLS = 2'd1;

	localparam logic [2:0] CMD_CLEAR    = 3'd0;
	localparam logic [2:0] CMD_RECT     = 3'd1;
	localparam logic [2:0] CMD_TRI_DOWN = 3'd2;
	localparam logic [2:0] CMD_TRI_UP   = 3'd3;
	localparam logic [2:0] CMD_DIAMOND  = 3'd4;
	localparam logic [2:0] CMD_READ     = 3'd5;

	typedef struct packed {
		logic [2:0]        cmd;
		logic signed [7:0] pos_x;
		logic signed [7:0] pos_y;
		logic [6:0]        width;
		logic [6:0]        height;
		logic [7:0]        brush;
	} cmd_word_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic       status;
	} result_word_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} mem_req_t;

	typedef struct packed {
		logic busy;
		logic fin;
		logic fin_oob;
		logic fin_read;
	} ctrl_stat_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_ROW,
		ST_SPAN,
		ST_READ
	} state_t;

endpackage

@@ sv/frs_ram.sv @@
`timescale 1ns / 1ps

module frs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/frs_ctrl.sv @@
`timescale 1ns / 1ps

module frs_ctrl
	import frs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cmd_word_t         command,
	input  logic [RUSE_W-1:0] rows_use,
	input  logic [CUSE_W-1:0] cols_use,
	output mem_req_t          mem_req,
	output ctrl_stat_t        stat
);

	state_t state_q, state_d;

	logic [ADDR_W-1:0] sweep_q;
	logic [2:0]        shape_q;
	logic signed [7:0] x_q, y_q;
	logic [6:0]        w_q, h_q;
	logic [7:0]        brush_q;
	logic [7:0]        nrows_q, i_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q, col_end_q;

	logic signed [GEO_W-1:0] iv, xv, yv, ev, r_s, c0_s, c1_s, c0c_s, c1c_s;
	logic signed [GEO_W-1:0] rows_s, cols_s, rx_s, ry_s;
	logic sweep_last, row_done, span_ok, col_last, rd_in, accept;
	logic [7:0] nrows_d;

	assign accept     = start && (state_q == ST_IDLE);
	assign sweep_last = (sweep_q == ADDR_W'(DEPTH - 1));
	assign row_done   = (i_q == nrows_q);
	assign col_last   = (col_q == col_end_q);

	assign rows_s = $signed(GEO_W'(rows_use));
	assign cols_s = $signed(GEO_W'(cols_use));

	// row geometry for row index i
	always_comb begin
		iv = $signed(GEO_W'(i_q));
		xv = GEO_W'(x_q);
		yv = GEO_W'(y_q);
		if (shape_q == CMD_DIAMOND && i_q > {1'b0, h_q}) begin
			ev = $signed(GEO_W'({h_q, 1'b0})) - iv;
		end else begin
			ev = iv;
		end
		r_s = (shape_q == CMD_TRI_DOWN) ? (yv - iv) : (yv + iv);
		if (shape_q == CMD_RECT) begin
			c0_s = xv;
			c1_s = xv + $signed(GEO_W'(w_q)) - $signed(GEO_W'(1));
		end else begin
			c0_s = xv - ev;
			c1_s = xv + ev;
		end
		c0c_s = (c0_s < 0) ? '0 : c0_s;
		c1c_s = (c1_s >= cols_s) ? (cols_s - $signed(GEO_W'(1))) : c1_s;
		span_ok = (r_s >= 0) && (r_s < rows_s) && (c0c_s <= c1c_s);
	end

	assign rx_s  = GEO_W'(command.pos_x);
	assign ry_s  = GEO_W'(command.pos_y);
	assign rd_in = (rx_s >= 0) && (ry_s >= 0) && (rx_s < cols_s) && (ry_s < rows_s);

	always_comb begin
		unique case (command.cmd)
			CMD_RECT:                nrows_d = (command.width == 7'd0) ? 8'd0
			                                   : {1'b0, command.height};
			CMD_TRI_DOWN, CMD_TRI_UP: nrows_d = {1'b0, command.height};
			CMD_DIAMOND:             nrows_d = {command.height, 1'b1};
			default:                 nrows_d = 8'd0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				if (sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					unique case (command.cmd)
						CMD_CLEAR:                         state_d = ST_CLEAR;
						CMD_RECT, CMD_TRI_DOWN, CMD_TRI_UP,
						CMD_DIAMOND:                       state_d = ST_ROW;
						CMD_READ:                          state_d = rd_in ? ST_READ : ST_IDLE;
						default:                           state_d = ST_IDLE;
					endcase
				end
			end
			ST_ROW: begin
				if (row_done) state_d = ST_IDLE;
				else if (span_ok) state_d = ST_SPAN;
			end
			ST_SPAN: begin
				if (col_last) state_d = ST_ROW;
			end
			ST_READ: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_req       = '0;
		stat          = '0;
		stat.busy     = (state_q != ST_IDLE);
		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = sweep_q;
				mem_req.wdata = BLANK_CELL;
				stat.fin      = (state_q == ST_CLEAR) && sweep_last;
			end
			ST_IDLE: begin
				if (start) begin
					if (command.cmd == CMD_READ) begin
						mem_req.re   = rd_in;
						mem_req.addr = ADDR_W'(32'($unsigned(command.pos_y)) * MAX_COLS
						               + 32'($unsigned(command.pos_x)));
						stat.fin     = !rd_in;
						stat.fin_oob = !rd_in;
					end else if (command.cmd > CMD_READ) begin
						stat.fin = 1'b1;
					end
				end
			end
			ST_ROW: stat.fin = row_done;
			ST_SPAN: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = ADDR_W'(32'(row_q) * MAX_COLS + 32'(col_q));
				mem_req.wdata = brush_q;
			end
			ST_READ: begin
				stat.fin      = 1'b1;
				stat.fin_read = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			sweep_q <= '0;
			i_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT || state_q == ST_CLEAR) begin
				sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
			end
			if (accept) begin
				i_q <= '0;
			end else if ((state_q == ST_ROW && !row_done && !span_ok)
			             || (state_q == ST_SPAN && col_last)) begin
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			shape_q <= command.cmd;
			x_q     <= command.pos_x;
			y_q     <= command.pos_y;
			w_q     <= command.width;
			h_q     <= command.height;
			brush_q <= command.brush;
			nrows_q <= nrows_d;
		end
		if (state_q == ST_ROW) begin
			row_q     <= r_s[ROW_W-1:0];
			col_q     <= c0c_s[COL_W-1:0];
			col_end_q <= c1c_s[COL_W-1:0];
		end else if (state_q == ST_SPAN) begin
			col_q <= col_q + 1'b1;
		end
	end

endmodule

@@ sv/filled_shape_rasterizer_core.sv @@
`timescale 1ns / 1ps

// channel   ports                         handshake
// command   start, command (cmd_word_t)   taken when start && !busy
// result    done, result (result_word_t)  one-cycle strobe, no back pressure
// config    cfg_we, cfg_index, cfg_data   written when cfg_we
//
// Reset starts a blanking pass over all MAX_ROWS*MAX_COLS cells (4096); busy is high meanwhile.
// Clear takes the same pass. A read issues the RAM read in the accept cycle and
// finishes in ST_READ; out-of-canvas reads and unused codes finish in the accept
// cycle. A shape visits each row in ST_ROW, writes each clipped cell through the
// canvas RAM write port in ST_SPAN, and closes in ST_ROW once all rows are done.
// The result strobe is registered and comes in the cycle after the command finishes; nothing stalls it.

module filled_shape_rasterizer_core
	import frs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  cmd_word_t            command,
	output logic                 busy,
	output logic                 done,
	output result_word_t         result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [6:0]        canvas_rows_q, canvas_cols_q;
	logic [RUSE_W-1:0] rows_use;
	logic [CUSE_W-1:0] cols_use;
	mem_req_t          mem_req;
	ctrl_stat_t        stat;
	logic [7:0]        rdata;
	logic              done_q;
	result_word_t      result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_rows_q <= CANVAS_RESET;
			canvas_cols_q <= CANVAS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_CANVAS_ROWS) canvas_rows_q <= cfg_data;
			if (cfg_index == REG_CANVAS_COLS) canvas_cols_q <= cfg_data;
		end
	end

	assign rows_use = (32'(canvas_rows_q) > MAX_ROWS) ? RUSE_W'(MAX_ROWS)
	                                                  : RUSE_W'(canvas_rows_q);
	assign cols_use = (32'(canvas_cols_q) > MAX_COLS) ? CUSE_W'(MAX_COLS)
	                                                  : CUSE_W'(canvas_cols_q);

	frs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.command  (command),
		.rows_use (rows_use),
		.cols_use (cols_use),
		.mem_req  (mem_req),
		.stat     (stat)
	);

	frs_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_canvas (
		.clk   (clk),
		.we    (mem_req.we),
		.re    (mem_req.re),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= stat.fin;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.fin) begin
			result_q.pixel  <= stat.fin_read ? rdata : 8'd0;
			result_q.status <= stat.fin_oob;
		end
	end

	assign busy   = stat.busy;
	assign done   = done_q;
	assign result = result_q;

	a_mem_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.we && mem_req.re))
		else $error("canvas RAM read and write in the same cycle");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result word without a command");

	a_oob_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status) |-> (result.pixel == 8'd0))
		else $error("out-of-canvas read returned a nonzero pixel");

endmodule
